// ===== hw/rtl/chp_pkg.sv =====
// Chunk header parse/check: shared constants, status codes and types.
// Used by chp_hdr_parse, chp_manifest_check, the top level and the checker.
// No dependencies.
package chp_pkg;

  localparam int unsigned HDR_LEN    = 32;
  localparam int unsigned HDR_BITS   = HDR_LEN * 8;
  localparam int unsigned CNT_W      = 6;
  localparam logic [CNT_W-1:0] CNT_LAST_BYTE = CNT_W'(HDR_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_STORE_LIM = CNT_W'(HDR_LEN);
  localparam logic [CNT_W-1:0] CNT_SAT       = CNT_W'(HDR_LEN + 1);

  localparam logic [31:0] HDR_MAGIC = 32'h5042_4348;

  // result status codes
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_LENGTH = 2'd1;
  localparam logic [1:0] ST_MAGIC  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SESSION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE  = 2'd3;
  localparam int unsigned CFG_DATA_W = 64;

  // output stream: 226 bits of fields, padded to whole bytes
  localparam int unsigned OUT_FIELD_W = 2 + 64 + 64 + 64 + 32;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] session;
    logic [63:0] chunk_num;
    logic [63:0] file_pos;
    logic [31:0] pay_len;
  } hdr_item_t;

  typedef struct packed {
    logic [63:0] expected_session;
    logic [63:0] total_chunks;
    logic [31:0] nominal_chunk_bytes;
    logic [63:0] total_file_bytes;
  } cfg_t;

endpackage

// ===== hw/rtl/chp_hdr_parse.sv =====
// Byte collector: counts header bytes, keeps them in a shift line and on the
// marked byte issues the decoded fields with a length/magic pre-status.
// Depends on chp_pkg.
module chp_hdr_parse
  import chp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data,
  input  logic            in_last,
  output logic            item_valid,
  input  logic            item_ready,
  output hdr_item_t       item
);

  logic [CNT_W-1:0]    byte_count;
  logic [HDR_BITS-1:0] hdr;
  logic [HDR_BITS-1:0] hdr_next;
  logic                accept;
  logic                full;
  hdr_item_t           item_next;

  assign in_ready = !item_valid || item_ready;
  assign accept   = in_valid && in_ready;
  assign hdr_next = {hdr[HDR_BITS-9:0], in_data};
  // frame is well sized only if this marked byte is the 32nd
  assign full     = (byte_count == CNT_LAST_BYTE);

  always_comb begin
    item_next = '0;
    if (!full) begin
      item_next.status = ST_LENGTH;
    end else if (hdr_next[255:224] != HDR_MAGIC) begin
      item_next.status = ST_MAGIC;
    end else begin
      item_next.status    = ST_ACCEPT;
      item_next.session   = hdr_next[223:160];
      item_next.chunk_num = hdr_next[159:96];
      item_next.file_pos  = hdr_next[95:32];
      item_next.pay_len   = hdr_next[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      item_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) begin
          byte_count <= '0;
        end else if (byte_count < CNT_SAT) begin
          byte_count <= byte_count + 1'b1;
        end
      end
      if (accept && in_last) begin
        item_valid <= 1'b1;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (byte_count < CNT_STORE_LIM)) begin
      hdr <= hdr_next;
    end
    if (accept && in_last) begin
      item <= item_next;
    end
  end

endmodule

// ===== hw/rtl/chp_manifest_check.sv =====
// Manifest check pipeline: offset product in two 32x32 halves, range and size
// compares, then the final status into the output register.
// Depends on chp_pkg.
module chp_manifest_check
  import chp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  hdr_item_t  in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output hdr_item_t  out_item
);

  logic s2_v, s3_v, s4_v;
  logic s2_rdy, s3_rdy, s4_rdy, o_rdy;

  hdr_item_t   s2_item, s3_item, s4_item;
  logic [63:0] s2_plo, s3_plo;
  logic [31:0] s3_phi;
  logic        s3_fa, s4_fa, s4_fb, s4_prod_ok;

  logic [63:0] plo_c;
  logic [31:0] phi_c;
  logic        fa_c, fb_c, prod_ok_c, last_chunk_c;
  logic [63:0] prod_c, end_sum_c, remain_c;
  hdr_item_t   out_next;

  assign o_rdy    = !out_valid || out_ready;
  assign s4_rdy   = !s4_v || o_rdy;
  assign s3_rdy   = !s3_v || s4_rdy;
  assign s2_rdy   = !s2_v || s3_rdy;
  assign in_ready = s2_rdy;

  // stage 2: low half of index * chunk size
  assign plo_c = in_item.chunk_num[31:0] * cfg.nominal_chunk_bytes;

  // stage 3: high half (only its low 32 bits survive the wrap), plain compares
  assign phi_c = s2_item.chunk_num[63:32] * cfg.nominal_chunk_bytes;
  assign fa_c  = (cfg.nominal_chunk_bytes != '0)
              && (s2_item.chunk_num < cfg.total_chunks)
              && (s2_item.pay_len != '0)
              && (s2_item.pay_len <= cfg.nominal_chunk_bytes)
              && (s2_item.session == cfg.expected_session);

  // stage 4: offset against product, file bounds, exact size
  assign prod_c       = s3_plo + {s3_phi, 32'b0};
  assign prod_ok_c    = (s3_item.file_pos == prod_c);
  assign end_sum_c    = s3_item.file_pos + {32'b0, s3_item.pay_len};
  assign remain_c     = cfg.total_file_bytes - s3_item.file_pos;
  assign last_chunk_c = ((s3_item.chunk_num + 64'd1) == cfg.total_chunks);
  assign fb_c = (s3_item.file_pos < cfg.total_file_bytes)
             && (end_sum_c <= cfg.total_file_bytes)
             && (last_chunk_c ? ({32'b0, s3_item.pay_len} == remain_c)
                              : (s3_item.pay_len == cfg.nominal_chunk_bytes));

  always_comb begin
    out_next = s4_item;
    if (s4_item.status == ST_ACCEPT) begin
      out_next.status = (s4_fa && s4_fb && s4_prod_ok) ? ST_ACCEPT : ST_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_rdy) s2_v <= in_valid;
      if (s3_rdy) s3_v <= s2_v;
      if (s4_rdy) s4_v <= s3_v;
      if (o_rdy)  out_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && in_valid) begin
      s2_item <= in_item;
      s2_plo  <= plo_c;
    end
    if (s3_rdy && s2_v) begin
      s3_item <= s2_item;
      s3_plo  <= s2_plo;
      s3_phi  <= phi_c;
      s3_fa   <= fa_c;
    end
    if (s4_rdy && s3_v) begin
      s4_item    <= s3_item;
      s4_fa      <= s3_fa;
      s4_fb      <= fb_c;
      s4_prod_ok <= prod_ok_c;
    end
    if (o_rdy && s4_v) begin
      out_item <= out_next;
    end
  end

endmodule

// ===== hw/rtl/chunk_header_parse_check.sv =====
// Chunk header parser and manifest checker.
// Slave stream: one header byte per transaction in s_tdata, s_tlast on the
// final byte of a frame. A well-formed frame is 32 bytes, big-endian: magic,
// session, chunk index, byte offset, payload size.
// Master stream: one result transaction per frame, issued for every byte
// marked with s_tlast; status plus the decoded fields (zero on a length or
// magic fault).
// Config port: cfg_we writes cfg_data into register cfg_index (0 session,
// 1 chunk count, 2 chunk size, 3 file size); write only while idle.
// Throughput: one byte per cycle, sustained, across frame boundaries, while
// the result path is not blocked by a low m_tready.
// Path: the result passes the collector register, two multiply stages for the
// 64x32 offset product, the compare stage and the output register.
// Reset (rst, synchronous): byte count, pipeline valids and config cleared.
// When m_tready is low the result holds in the output register; the stages
// behind it keep filling their bubbles, and s_tready drops only once the
// collector register itself is full and blocked.
// Depends on chp_pkg, chp_hdr_parse, chp_manifest_check.
module chunk_header_parse_check
  import chp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,   // last_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] status, [65:2] session, [129:66] chunk number,
  // [193:130] file offset, [225:194] payload length, [231:226] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      item_valid;
  logic      item_ready;
  hdr_item_t item;
  hdr_item_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SESSION:    cfg.expected_session    <= cfg_data;
        REG_CHUNKS:     cfg.total_chunks        <= cfg_data;
        REG_CHUNK_SIZE: cfg.nominal_chunk_bytes <= cfg_data[31:0];
        REG_FILE_SIZE:  cfg.total_file_bytes    <= cfg_data;
        default: ;
      endcase
    end
  end

  chp_hdr_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_last    (s_tlast),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  chp_manifest_check u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_item   (item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (result)
  );

  assign m_tdata = {(OUT_DATA_W - OUT_FIELD_W)'(0), result.pay_len,
                    result.file_pos, result.chunk_num, result.session,
                    result.status};

endmodule

// ===== hw/rtl/chp_checker.sv =====
// Port-level checks for chunk_header_parse_check, bound to the top level.
// Depends on chp_pkg.
module chp_props
  import chp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_fault_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_LENGTH || m_tdata[1:0] == ST_MAGIC)
      |-> m_tdata[OUT_DATA_W-1:2] == '0)
    else $error("length or magic fault carries nonzero fields");

  a_accept_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_ACCEPT |-> m_tdata[225:194] != '0)
    else $error("accepted header with empty payload");

endmodule

bind chunk_header_parse_check chp_props u_chp_props (.*);

// ===== dv/chp_checker.sv =====
// Checker for chunk_header_parse_check: watches both streams and the register
// port, predicts one result per frame and compares results field by field.
// Depends on chp_pkg.
module chp_checker
  import chp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,   // last_byte
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] status, [65:2] session, [129:66] chunk number,
  // [193:130] file offset, [225:194] payload length, [231:226] zero
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fails,
  output int                    outstanding,
  output int                    results_seen,
  output int                    accepted_seen
);

  logic [7:0]       hdr_mem [HDR_LEN];
  logic [CNT_W-1:0] frame_len;
  logic [63:0]      cfg_session;
  logic [63:0]      cfg_chunks;
  logic [31:0]      cfg_csz;
  logic [63:0]      cfg_file;
  hdr_item_t        frame_results_q [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fails++;
    if (fails <= 20)
      $display("[%0t] result %0d: %s mismatch, got %h want %h",
               $realtime, results_seen, what, got, want);
  endtask

  // big-endian field from the stored header bytes
  function automatic logic [63:0] be_field(input int start, input int len);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < len; i++)
      v = {v[55:0], hdr_mem[start + i]};
    return v;
  endfunction

  // manifest rules; all sums and products wrap at 64 bits
  function automatic bit manifest_pass(input logic [63:0] sess, input logic [63:0] idx,
                                       input logic [63:0] off, input logic [31:0] size);
    logic [63:0] csz;
    logic [63:0] size64;
    logic [63:0] prod;
    logic [63:0] end_pos;
    logic [63:0] want;
    csz     = {32'd0, cfg_csz};
    size64  = {32'd0, size};
    prod    = idx * csz;
    end_pos = off + size64;
    if (csz == '0 || idx >= cfg_chunks || size64 == '0 || size64 > csz ||
        sess != cfg_session)
      return 1'b0;
    if (off != prod || off >= cfg_file || end_pos > cfg_file)
      return 1'b0;
    want = (idx + 64'd1 == cfg_chunks) ? cfg_file - off : csz;
    return size64 == want;
  endfunction

  task automatic absorb_header_byte(input logic [7:0] b, input logic last);
    hdr_item_t   r;
    logic [63:0] size64;
    if (frame_len < CNT_STORE_LIM)
      hdr_mem[frame_len] = b;
    if (frame_len < CNT_SAT)
      frame_len = frame_len + 1'b1;
    if (last) begin
      r = '0;
      if (frame_len != CNT_STORE_LIM) begin
        r.status = ST_LENGTH;
      end else if (be_field(0, 4) != {32'd0, HDR_MAGIC}) begin
        r.status = ST_MAGIC;
      end else begin
        size64      = be_field(28, 4);
        r.session   = be_field(4, 8);
        r.chunk_num = be_field(12, 8);
        r.file_pos  = be_field(20, 8);
        r.pay_len   = size64[31:0];
        r.status = manifest_pass(r.session, r.chunk_num, r.file_pos,
                                 r.pay_len) ? ST_ACCEPT : ST_REJECT;
      end
      frame_len = '0;
      frame_results_q.insert(frame_results_q.size(), r);
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    hdr_item_t want;
    if (frame_results_q.size() == 0) begin
      report("unexpected transaction", d[63:0], '0);
      return;
    end
    want = frame_results_q.pop_front();
    if (d[1:0] !== want.status)
      report("status", 64'(d[1:0]), 64'(want.status));
    if (d[65:2] !== want.session)
      report("session", d[65:2], want.session);
    if (d[129:66] !== want.chunk_num)
      report("chunk number", d[129:66], want.chunk_num);
    if (d[193:130] !== want.file_pos)
      report("file offset", d[193:130], want.file_pos);
    if (d[225:194] !== want.pay_len)
      report("payload length", 64'(d[225:194]), 64'(want.pay_len));
    if (d[OUT_DATA_W-1:OUT_FIELD_W] !== '0)
      report("padding", 64'(d[OUT_DATA_W-1:OUT_FIELD_W]), '0);
    results_seen++;
    if (want.status == ST_ACCEPT)
      accepted_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_len   = '0;
      cfg_session = '0;
      cfg_chunks  = '0;
      cfg_csz     = '0;
      cfg_file    = '0;
      frame_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SESSION:    cfg_session = cfg_data;
          REG_CHUNKS:     cfg_chunks  = cfg_data;
          REG_CHUNK_SIZE: cfg_csz     = cfg_data[31:0];
          REG_FILE_SIZE:  cfg_file    = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready)
        check_result(m_tdata);
      if (s_tvalid && s_tready)
        absorb_header_byte(s_tdata, s_tlast);
    end
    outstanding = frame_results_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top-level testbench for chunk_header_parse_check: clock, reset, header
// frames, register settings and flow control; verdict from chp_checker.
// Depends on chp_pkg, chp_checker and the block itself.
module tb;
  import chp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 190;
  localparam int SETTLE       = 8;
  localparam int N_PHASES     = 8;

  typedef enum {CFG_MATCHED, CFG_ZERO_SIZE, CFG_ALL_ONES, CFG_ONE_CHUNK,
                CFG_ALL_ZERO} cfg_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;     // [7:0] data_byte
  logic                  s_tlast = 1'b0;   // last_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [1:0] status, [65:2] session, [129:66] chunk number,
  // [193:130] file offset, [225:194] payload length, [231:226] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fails;
  int outstanding;
  int results_seen;
  int accepted_seen;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit hold_go       = 1'b0;
  int hold_count    = 0;
  int bytes_sent    = 0;
  int frames_sent   = 0;
  int cycle_count   = 0;

  // register copies used to build matching headers
  logic [63:0] cur_session = '0;
  logic [63:0] cur_chunks  = '0;
  logic [31:0] cur_csz     = '0;
  logic [63:0] cur_file    = '0;

  cfg_kind_t phase_cfg [N_PHASES] = '{CFG_MATCHED, CFG_MATCHED, CFG_ZERO_SIZE, CFG_MATCHED,
                                      CFG_ALL_ONES, CFG_ONE_CHUNK, CFG_MATCHED, CFG_ALL_ZERO};

  chunk_header_parse_check i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chp_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .accepted_seen (accepted_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off while frames keep coming
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go && hold_count < HOLD_CYCLES) begin
        m_tready = 1'b0;
        hold_count++;
      end else begin
        m_tready = ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // header that passes the manifest checks for the current settings
  function automatic logic [255:0] good_header(input logic [63:0] idx);
    logic [63:0] off;
    logic [63:0] rest;
    logic [31:0] size;
    off  = idx * {32'd0, cur_csz};
    rest = cur_file - off;
    size = (idx + 64'd1 == cur_chunks) ? rest[31:0] : cur_csz;
    return {HDR_MAGIC, cur_session, idx, off, size};
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
    bytes_sent++;
  endtask

  // bytes past the 32nd are random filler
  task automatic send_frame(input logic [255:0] hdr, input int len);
    for (int i = 0; i < len; i++)
      push_byte((i < 32) ? hdr[255 - 8*i -: 8] : 8'($urandom), i == len - 1);
    frames_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_config(input cfg_kind_t kind);
    logic [63:0] sess;
    logic [63:0] chunks;
    logic [63:0] file;
    logic [31:0] csz;
    logic [31:0] tail;
    sess   = rand64();
    chunks = 64'($urandom_range(1, 40));
    csz    = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h8000_0000) : $urandom_range(1, 600);
    tail   = $urandom_range(1, csz);
    file   = (chunks - 64'd1) * {32'd0, csz} + {32'd0, tail};
    case (kind)
      CFG_ZERO_SIZE: begin
        sess = '1;
        csz  = '0;
        file = rand64();
      end
      CFG_ALL_ONES: begin
        sess   = '1;
        chunks = '1;
        csz    = '1;
        file   = '1;
      end
      CFG_ONE_CHUNK: begin
        chunks = 64'd1;
        file   = {32'd0, tail};
      end
      CFG_ALL_ZERO: begin
        sess   = '0;
        chunks = '0;
        csz    = '0;
        file   = '0;
      end
      default: ;
    endcase
    write_reg(REG_SESSION, sess);
    write_reg(REG_CHUNKS, chunks);
    write_reg(REG_CHUNK_SIZE, {$urandom, csz});   // upper half must be ignored
    write_reg(REG_FILE_SIZE, file);
    cur_session = sess;
    cur_chunks  = chunks;
    cur_csz     = csz;
    cur_file    = file;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic settle_and_load(input cfg_kind_t kind);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    load_config(kind);
  endtask

  // mostly well-formed headers, some with one field disturbed, some mis-sized
  task automatic random_frame();
    logic [255:0] hdr;
    logic [63:0]  idx;
    int           roll;
    int           len;
    idx = rand64();
    if (cur_chunks != '0)
      idx = ($urandom_range(0, 4) == 0) ? cur_chunks - 64'd1 : idx % cur_chunks;
    hdr  = good_header(idx);
    len  = 32;
    roll = $urandom_range(0, 99);
    if (roll >= 50 && roll < 85) begin
      case ($urandom_range(0, 8))
        0: hdr[223:160] ^= 64'd1 << $urandom_range(0, 63);
        1: hdr[159:96]  += 64'd1;
        2: hdr[159:96]  = cur_chunks;
        3: hdr[95:32]   ^= 64'd1 << $urandom_range(0, 63);
        4: hdr[31:0]    += 32'd1;
        5: hdr[31:0]    -= 32'd1;
        6: hdr[31:0]    = '0;
        7: hdr[255:224] ^= 32'd1 << $urandom_range(0, 31);
        default: hdr[223:0] = {rand64(), rand64(), rand64(), 32'($urandom)};
      endcase
    end else if (roll >= 85 && roll < 93) begin
      len = $urandom_range(1, 31);
    end else if (roll >= 93) begin
      len = $urandom_range(33, 40);
    end
    send_frame(hdr, len);
  endtask

  initial begin
    logic [255:0] hdr;
    int           phase_start;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: registers still at reset, so a full header is rejected
    send_frame(good_header('0), 1);
    hdr = good_header('0);
    hdr[31:0] = 32'd1;
    send_frame(hdr, 32);
    send_frame('1, 32);
    settle_and_load(CFG_MATCHED);
    send_frame(good_header('0), 32);
    send_frame(good_header(cur_chunks - 64'd1), 32);
    send_frame(good_header(cur_chunks), 32);
    send_frame(good_header('0) ^ {HDR_MAGIC, 224'd0}, 32);
    hdr = good_header('0);
    hdr[31:0] = '0;
    send_frame(hdr, 32);
    send_frame(good_header('0), 31);
    send_frame(good_header('0), 35);

    for (int p = 0; p < N_PHASES; p++) begin
      settle_and_load(phase_cfg[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
        default: begin src_idle_pct = 38; snk_stall_pct = 38; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        random_frame();
        // back-pressure: receiver holds off while short frames pile up
        if (p == 0 && !hold_go && bytes_sent - phase_start > PHASE_BYTES / 2) begin
          hold_go = 1'b1;
          repeat (40) send_frame(good_header('0), $urandom_range(1, 3));
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("sent %0d frames (%0d bytes) over %0d register settings",
             frames_sent, bytes_sent, N_PHASES + 2);
    $display("and four flow-control mixes; checked %0d results, %0d accepted headers",
             results_seen, accepted_seen);
    if (fails == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", fails, outstanding);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
